FILE: rtl/sha256_byte_stream_hasher_macros.svh
// assertion macros shared by the sha-256 byte stream hasher rtl
// expects clk and rst_n in the scope of the including module
`ifndef SHA256_BYTE_STREAM_HASHER_MACROS_SVH
`define SHA256_BYTE_STREAM_HASHER_MACROS_SVH

// antecedent implies consequent in the same cycle
`define SHABSH_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sha256 hasher check failed");

// antecedent implies consequent in the next cycle
`define SHABSH_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sha256 hasher check failed");

`endif

FILE: rtl/shabsh_pkg.sv
// shared types, constants and sigma functions of the sha-256 byte stream hasher
// no dependencies
`default_nettype none

package shabsh_pkg;

    typedef logic [31:0] word_t;

    localparam logic FUNC_ABSORB = 1'b0;
    localparam logic FUNC_FINISH = 1'b1;

    localparam logic [7:0] PAD_MARKER = 8'h80;

    localparam word_t INIT_H [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam word_t ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    // controls of the message window
    typedef struct packed {
        logic byte_shift;
        logic word_shift;
    } sched_ctrl_t;

    // controls of the round unit and chain value
    typedef struct packed {
        logic load;
        logic step;
        logic fold;
        logic init;
    } round_ctrl_t;

    function automatic word_t rotr(input word_t x, input int unsigned n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

    function automatic word_t big_sigma0(input word_t x);
        big_sigma0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic word_t big_sigma1(input word_t x);
        big_sigma1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic word_t small_sigma0(input word_t x);
        small_sigma0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic word_t small_sigma1(input word_t x);
        small_sigma1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

endpackage

`default_nettype wire

FILE: rtl/shabsh_sched.sv
// block buffer and message schedule: a 16-word window that takes bytes while
// filling and expands one schedule word per round; uses shabsh_pkg
`default_nettype none

module shabsh_sched (
    input  wire logic                     clk,
    input  wire shabsh_pkg::sched_ctrl_t  ctrl,
    input  wire logic [7:0]               byte_in,
    output shabsh_pkg::word_t             w_cur
);

    shabsh_pkg::word_t win_reg [16];
    shabsh_pkg::word_t w_new;

    // w[i+16] from the taps of the window
    always_comb
    begin
        w_new = shabsh_pkg::small_sigma1(win_reg[14]) + win_reg[9]
              + shabsh_pkg::small_sigma0(win_reg[1]) + win_reg[0];
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.byte_shift)
        begin
            // whole window moves up one byte, first byte ends in the top of word 0
            for (int k = 0; k < 15; k++)
            begin
                win_reg[k] <= {win_reg[k][23:0], win_reg[k+1][31:24]};
            end
            win_reg[15] <= {win_reg[15][23:0], byte_in};
        end
        else if (ctrl.word_shift)
        begin
            for (int k = 0; k < 15; k++)
            begin
                win_reg[k] <= win_reg[k+1];
            end
            win_reg[15] <= w_new;
        end
    end

    assign w_cur = win_reg[0];

endmodule

`default_nettype wire

FILE: rtl/shabsh_round.sv
// shared compression round unit with working variables and chain value
// uses shabsh_pkg for round constants, initial values and sigma functions
`default_nettype none

module shabsh_round (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire shabsh_pkg::round_ctrl_t  ctrl,
    input  wire logic [5:0]               round_idx,
    input  wire shabsh_pkg::word_t        w,
    input  wire logic [2:0]               word_sel,
    output shabsh_pkg::word_t             chain_word
);

    shabsh_pkg::word_t v_reg     [8];
    shabsh_pkg::word_t chain_reg [8];
    shabsh_pkg::word_t t1;
    shabsh_pkg::word_t t2;
    shabsh_pkg::word_t pick;
    shabsh_pkg::word_t vote;

    always_comb
    begin
        pick = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
        vote = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
        t1   = v_reg[7] + shabsh_pkg::big_sigma1(v_reg[4]) + pick
             + shabsh_pkg::ROUND_K[round_idx] + w;
        t2   = shabsh_pkg::big_sigma0(v_reg[0]) + vote;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            for (int i = 0; i < 8; i++)
            begin
                v_reg[i] <= chain_reg[i];
            end
        end
        else if (ctrl.step)
        begin
            v_reg[7] <= v_reg[6];
            v_reg[6] <= v_reg[5];
            v_reg[5] <= v_reg[4];
            v_reg[4] <= v_reg[3] + t1;
            v_reg[3] <= v_reg[2];
            v_reg[2] <= v_reg[1];
            v_reg[1] <= v_reg[0];
            v_reg[0] <= t1 + t2;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 8; i++)
            begin
                chain_reg[i] <= shabsh_pkg::INIT_H[i];
            end
        end
        else if (ctrl.init)
        begin
            for (int i = 0; i < 8; i++)
            begin
                chain_reg[i] <= shabsh_pkg::INIT_H[i];
            end
        end
        else if (ctrl.fold)
        begin
            for (int i = 0; i < 8; i++)
            begin
                chain_reg[i] <= chain_reg[i] + v_reg[i];
            end
        end
    end

    assign chain_word = chain_reg[word_sel];

endmodule

`default_nettype wire

FILE: rtl/sha256_byte_stream_hasher.sv
// SHA-256 over a byte stream, one byte per input transfer. The byte that completes
// a 64-byte block starts the rounds of the single shared round unit, after which the
// result is folded into the chain value. A finish transfer shifts in padding and the
// length one byte per cycle (up to 72 bytes over one or two blocks, each followed by
// its rounds and a fold), then gives the eight digest words, H0 first, as eight
// output transfers and returns to the initial state. The input is not ready while
// rounds, padding or digest output are in progress.
// depends on shabsh_pkg, shabsh_sched, shabsh_round and the macros header
`default_nettype none

module sha256_byte_stream_hasher (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // message_byte
    input  wire logic        s_axis_tuser,   // func
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,   // digest_word
    output logic [2:0]       m_axis_tuser,   // word_index
    output logic             m_axis_tlast
);

`include "sha256_byte_stream_hasher_macros.svh"

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_PAD   = 5'b00010,
        ST_ROUND = 5'b00100,
        ST_FOLD  = 5'b01000,
        ST_OUT   = 5'b10000
    } state_t;

    state_t      state_reg, state_next;
    logic [5:0]  fill_reg, fill_next;
    logic [5:0]  round_reg, round_next;
    logic [2:0]  word_reg, word_next;
    logic [63:0] msg_len_reg, msg_len_next;
    logic [63:0] len_shift_reg, len_shift_next;
    logic        marker_sent_reg, marker_sent_next;
    logic        len_ok_reg, len_ok_next;
    logic        last_block_reg, last_block_next;
    logic        finishing_reg, finishing_next;

    shabsh_pkg::sched_ctrl_t sctrl;
    shabsh_pkg::round_ctrl_t rctrl;
    logic [7:0]              shift_byte;
    shabsh_pkg::word_t       w_cur;
    shabsh_pkg::word_t       chain_word;
    logic                    in_xfer;
    logic                    out_xfer;

    assign in_xfer  = s_axis_tvalid && s_axis_tready;
    assign out_xfer = m_axis_tvalid && m_axis_tready;

    always_comb
    begin
        state_next       = state_reg;
        fill_next        = fill_reg;
        round_next       = round_reg;
        word_next        = word_reg;
        msg_len_next     = msg_len_reg;
        len_shift_next   = len_shift_reg;
        marker_sent_next = marker_sent_reg;
        len_ok_next      = len_ok_reg;
        last_block_next  = last_block_reg;
        finishing_next   = finishing_reg;
        sctrl            = '0;
        rctrl            = '0;
        shift_byte       = s_axis_tdata;
        s_axis_tready    = 1'b0;
        m_axis_tvalid    = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (in_xfer)
                begin
                    if (s_axis_tuser == shabsh_pkg::FUNC_ABSORB)
                    begin
                        sctrl.byte_shift = 1'b1;
                        fill_next        = fill_reg + 6'd1;
                        msg_len_next     = msg_len_reg + 64'd8;
                        if (fill_reg == 6'd63)
                        begin
                            state_next     = ST_ROUND;
                            rctrl.load     = 1'b1;
                            round_next     = 6'd0;
                            finishing_next = 1'b0;
                        end
                    end
                    else
                    begin
                        state_next       = ST_PAD;
                        finishing_next   = 1'b1;
                        marker_sent_next = 1'b0;
                        len_ok_next      = 1'b0;
                        last_block_next  = 1'b0;
                        len_shift_next   = msg_len_reg;
                    end
                end
            end
            ST_PAD:
            begin
                sctrl.byte_shift = 1'b1;
                fill_next        = fill_reg + 6'd1;
                if (!marker_sent_reg)
                begin
                    shift_byte       = shabsh_pkg::PAD_MARKER;
                    marker_sent_next = 1'b1;
                    // room for the length in this block only below byte 56
                    len_ok_next      = (fill_reg[5:3] != 3'b111);
                end
                else if (len_ok_reg && (fill_reg[5:3] == 3'b111))
                begin
                    shift_byte     = len_shift_reg[63:56];
                    len_shift_next = {len_shift_reg[55:0], 8'h00};
                end
                else
                begin
                    shift_byte = 8'h00;
                end
                if (fill_reg == 6'd63)
                begin
                    state_next      = ST_ROUND;
                    rctrl.load      = 1'b1;
                    round_next      = 6'd0;
                    last_block_next = len_ok_reg && marker_sent_reg;
                end
            end
            ST_ROUND:
            begin
                rctrl.step       = 1'b1;
                sctrl.word_shift = 1'b1;
                round_next       = round_reg + 6'd1;
                if (round_reg == 6'd63)
                begin
                    state_next = ST_FOLD;
                end
            end
            ST_FOLD:
            begin
                rctrl.fold = 1'b1;
                if (!finishing_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (last_block_reg)
                begin
                    state_next = ST_OUT;
                    word_next  = 3'd0;
                end
                else
                begin
                    // extra block after a marker too late for the length
                    state_next  = ST_PAD;
                    len_ok_next = 1'b1;
                end
            end
            ST_OUT:
            begin
                m_axis_tvalid = 1'b1;
                if (out_xfer)
                begin
                    word_next = word_reg + 3'd1;
                    if (word_reg == 3'd7)
                    begin
                        state_next     = ST_IDLE;
                        rctrl.init     = 1'b1;
                        msg_len_next   = 64'd0;
                        finishing_next = 1'b0;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            fill_reg        <= 6'd0;
            round_reg       <= 6'd0;
            word_reg        <= 3'd0;
            msg_len_reg     <= 64'd0;
            marker_sent_reg <= 1'b0;
            len_ok_reg      <= 1'b0;
            last_block_reg  <= 1'b0;
            finishing_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            fill_reg        <= fill_next;
            round_reg       <= round_next;
            word_reg        <= word_next;
            msg_len_reg     <= msg_len_next;
            marker_sent_reg <= marker_sent_next;
            len_ok_reg      <= len_ok_next;
            last_block_reg  <= last_block_next;
            finishing_reg   <= finishing_next;
        end
    end

    always_ff @(posedge clk)
    begin
        len_shift_reg <= len_shift_next;
    end

    shabsh_sched u_sched (
        .clk     (clk),
        .ctrl    (sctrl),
        .byte_in (shift_byte),
        .w_cur   (w_cur)
    );

    shabsh_round u_round (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (rctrl),
        .round_idx  (round_reg),
        .w          (w_cur),
        .word_sel   (word_reg),
        .chain_word (chain_word)
    );

    assign m_axis_tdata = chain_word;
    assign m_axis_tuser = word_reg;
    assign m_axis_tlast = (word_reg == 3'd7);

    `SHABSH_ASSERT_NEXT(a_block_starts_rounds, in_xfer && !s_axis_tuser && fill_reg == 6'd63, state_reg == ST_ROUND && round_reg == 6'd0)
    `SHABSH_ASSERT_NEXT(a_rounds_end_in_fold, state_reg == ST_ROUND && round_reg == 6'd63, state_reg == ST_FOLD)
    `SHABSH_ASSERT_SAME(a_fold_after_full_count, state_reg == ST_FOLD, round_reg == 6'd0 && fill_reg == 6'd0)
    `SHABSH_ASSERT_NEXT(a_digest_end_clears, out_xfer && m_axis_tlast, state_reg == ST_IDLE && fill_reg == 6'd0 && msg_len_reg == 64'd0)

endmodule

`default_nettype wire

FILE: tb/sha256_byte_stream_hasher_checker.sv
// digest checker for the sha-256 byte stream hasher: watches both stream channels,
// hashes the accepted bytes itself and compares every digest word the block sends
// depends on shabsh_pkg for the func codes
module sha256_byte_stream_hasher_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,
    input  logic        s_axis_tuser,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [31:0] m_axis_tdata,
    input  logic [2:0]  m_axis_tuser,
    input  logic        m_axis_tlast,
    output int          fail_count,
    output int          words_pending,
    output int          digests_done,
    output int          bytes_absorbed
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [7:0] PAD_BYTE = 8'h80;

    localparam logic [31:0] IV [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] KTAB [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    typedef struct {
        logic [31:0] word;
        logic [2:0]  index;
        logic        last;
    } digest_beat_t;

    logic [31:0]  chain_h [8];
    logic [7:0]   block_bytes [64];
    logic [5:0]   fill_count;
    logic [63:0]  bit_total;
    digest_beat_t digest_expect_q [$];
    int           fail_total;
    int           digest_total;
    int           byte_total;

    assign fail_count     = fail_total;
    assign words_pending  = digest_expect_q.size();
    assign digests_done   = digest_total;
    assign bytes_absorbed = byte_total;

    initial
    begin
        fail_total   = 0;
        digest_total = 0;
        byte_total   = 0;
    end

    function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic void clear_hash_state();
        for (int i = 0; i < 8; i++)
            chain_h[i] = IV[i];
        for (int i = 0; i < 64; i++)
            block_bytes[i] = 8'h00;
        fill_count = '0;
        bit_total  = '0;
    endfunction

    function automatic void compress_block();
        logic [31:0] w [64];
        logic [31:0] v [8];
        logic [31:0] s0, s1, t1, t2, ch, maj;
        for (int i = 0; i < 16; i++)
            w[i] = {block_bytes[4*i], block_bytes[4*i+1], block_bytes[4*i+2], block_bytes[4*i+3]};
        for (int i = 16; i < 64; i++)
        begin
            s0 = ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3);
            s1 = ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10);
            w[i] = s1 + w[i-7] + s0 + w[i-16];
        end
        for (int i = 0; i < 8; i++)
            v[i] = chain_h[i];
        for (int i = 0; i < 64; i++)
        begin
            s1  = ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25);
            ch  = (v[4] & v[5]) ^ (~v[4] & v[6]);
            t1  = v[7] + s1 + ch + KTAB[i] + w[i];
            s0  = ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22);
            maj = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
            t2  = s0 + maj;
            v[7] = v[6];
            v[6] = v[5];
            v[5] = v[4];
            v[4] = v[3] + t1;
            v[3] = v[2];
            v[2] = v[1];
            v[1] = v[0];
            v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++)
            chain_h[i] = chain_h[i] + v[i];
    endfunction

    function automatic void absorb_byte(input logic [7:0] b);
        block_bytes[fill_count] = b;
        fill_count = fill_count + 6'd1;
        if (fill_count == 6'd0)
        begin
            compress_block();
            bit_total = bit_total + 64'd512;
        end
    endfunction

    // pad, fold the length in and queue the eight digest words
    function automatic void finish_message();
        int unsigned  pos;
        logic [63:0]  msg_bits;
        digest_beat_t beat;
        pos      = fill_count;
        msg_bits = bit_total + 64'(pos) * 64'd8;
        block_bytes[pos] = PAD_BYTE;
        for (int i = pos + 1; i < 64; i++)
            block_bytes[i] = 8'h00;
        if (pos >= 56)
        begin
            compress_block();
            for (int i = 0; i < 56; i++)
                block_bytes[i] = 8'h00;
        end
        for (int i = 0; i < 8; i++)
            block_bytes[63-i] = msg_bits[8*i +: 8];
        compress_block();
        for (int i = 0; i < 8; i++)
        begin
            beat.word  = chain_h[i];
            beat.index = 3'(i);
            beat.last  = (i == 7);
            digest_expect_q.push_back(beat);
        end
        clear_hash_state();
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        digest_beat_t want;
        if (!rst_n)
        begin
            clear_hash_state();
            digest_expect_q.delete();
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                if (s_axis_tuser == shabsh_pkg::FUNC_ABSORB)
                begin
                    absorb_byte(s_axis_tdata);
                    byte_total++;
                end
                else if (s_axis_tuser == shabsh_pkg::FUNC_FINISH)
                begin
                    finish_message();
                    digest_total++;
                end
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (digest_expect_q.size() == 0)
                begin
                    $display("%0t: unexpected digest transfer, actual word %h index %0d last %b",
                             $time, m_axis_tdata, m_axis_tuser, m_axis_tlast);
                    fail_total++;
                end
                else
                begin
                    want = digest_expect_q.pop_front();
                    if (m_axis_tdata !== want.word)
                    begin
                        $display("%0t: digest word mismatch, expected %h actual %h",
                                 $time, want.word, m_axis_tdata);
                        fail_total++;
                    end
                    if (m_axis_tuser !== want.index)
                    begin
                        $display("%0t: word index mismatch, expected %0d actual %0d",
                                 $time, want.index, m_axis_tuser);
                        fail_total++;
                    end
                    if (m_axis_tlast !== want.last)
                    begin
                        $display("%0t: last flag mismatch, expected %b actual %b",
                                 $time, want.last, m_axis_tlast);
                        fail_total++;
                    end
                end
            end
        end
    end

endmodule

FILE: tb/sha256_byte_stream_hasher_tb.sv
// top of the sha-256 byte stream hasher testbench: clock, reset, byte stream stimulus
// with bursty input and a stalling digest receiver, plus the final verdict
// depends on shabsh_pkg, the hasher rtl and sha256_byte_stream_hasher_checker
module sha256_byte_stream_hasher_tb;

    timeunit 1ns;
    timeprecision 1ps;

    typedef enum logic [1:0] {STALL_NONE, STALL_COIN, STALL_QUARTER, STALL_LONG} stall_style_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;   // message_byte
    logic        s_axis_tuser = shabsh_pkg::FUNC_ABSORB;   // func
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;   // digest_word
    logic [2:0]  m_axis_tuser;   // word_index
    logic        m_axis_tlast;

    int fail_count;
    int words_pending;
    int digests_done;
    int bytes_absorbed;

    int           burst_left = 0;
    stall_style_t stall_style = STALL_NONE;
    int unsigned  stall_tick = 0;

    sha256_byte_stream_hasher dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    sha256_byte_stream_hasher_checker checker_i (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_axis_tvalid  (s_axis_tvalid),
        .s_axis_tready  (s_axis_tready),
        .s_axis_tdata   (s_axis_tdata),
        .s_axis_tuser   (s_axis_tuser),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata),
        .m_axis_tuser   (m_axis_tuser),
        .m_axis_tlast   (m_axis_tlast),
        .fail_count     (fail_count),
        .words_pending  (words_pending),
        .digests_done   (digests_done),
        .bytes_absorbed (bytes_absorbed)
    );

    always #1 clk = ~clk;

    // receiver: switch between random stall styles
    always @(negedge clk)
    begin
        stall_tick <= stall_tick + 1;
        if (stall_tick % 50 == 0)
            stall_style <= stall_style_t'($urandom_range(0, 3));
        case (stall_style)
            STALL_NONE:    m_axis_tready <= 1'b1;
            STALL_COIN:    m_axis_tready <= 1'($urandom_range(0, 1));
            STALL_QUARTER: m_axis_tready <= (stall_tick[1:0] == 2'd0);
            default:       m_axis_tready <= (stall_tick[4:0] == 5'd0);
        endcase
    end

    // called and returns just after a falling edge
    task automatic send_item(input logic func, input logic [7:0] data);
        int gap;
        if (burst_left == 0)
        begin
            gap        = $urandom_range(0, 6);
            burst_left = $urandom_range(1, 16);
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                s_axis_tdata  <= 8'($urandom);
                s_axis_tuser  <= 1'($urandom);
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= data;
        s_axis_tuser  <= func;
        do
            @(posedge clk);
        while (!s_axis_tready);
        @(negedge clk);
    endtask

    // random bytes, then a finish with a junk byte that must be ignored
    task automatic hash_random_message(input int unsigned n_bytes);
        for (int i = 0; i < n_bytes; i++)
            send_item(shabsh_pkg::FUNC_ABSORB, 8'($urandom));
        send_item(shabsh_pkg::FUNC_FINISH, 8'($urandom));
    endtask

    initial
    begin
        int unsigned boundary_len [2];
        boundary_len = '{56, 64};
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // empty message, a single zero byte, then short messages of three and two bytes
        send_item(shabsh_pkg::FUNC_FINISH, 8'hff);
        send_item(shabsh_pkg::FUNC_ABSORB, 8'h00);
        send_item(shabsh_pkg::FUNC_FINISH, 8'h00);
        send_item(shabsh_pkg::FUNC_ABSORB, 8'h61);
        send_item(shabsh_pkg::FUNC_ABSORB, 8'h62);
        send_item(shabsh_pkg::FUNC_ABSORB, 8'h63);
        send_item(shabsh_pkg::FUNC_FINISH, 8'h5a);
        send_item(shabsh_pkg::FUNC_ABSORB, 8'hff);
        send_item(shabsh_pkg::FUNC_ABSORB, 8'h80);
        send_item(shabsh_pkg::FUNC_FINISH, 8'ha5);
        // back-to-back finish: second one hashes the empty message again
        send_item(shabsh_pkg::FUNC_FINISH, 8'h00);
        send_item(shabsh_pkg::FUNC_ABSORB, 8'h55);
        send_item(shabsh_pkg::FUNC_ABSORB, 8'haa);
        send_item(shabsh_pkg::FUNC_FINISH, 8'hff);

        // padding spills into a second block, exact full block
        foreach (boundary_len[i])
            hash_random_message(boundary_len[i]);

        s_axis_tvalid <= 1'b0;
        while (words_pending != 0)
            @(negedge clk);
        repeat (300) @(negedge clk);

        $display("hashed %0d messages over %0d absorbed bytes", digests_done, bytes_absorbed);
        $display("including empty messages and lengths 56 and 64 at the padding edges");
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial
    begin
        #1ms;
        $display("simulation failed");
        $finish;
    end

endmodule
